FILE: hdl/tilt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt filter package
// Shared constants, types and the CORDIC angle table for the tilt filter.
// ----------------------------------------------------------------------------
package tilt_pkg;

  localparam int CalibCountDefault = 256;
  localparam int CordicStepsDefault = 16;

  localparam int AccW = 40;   // CORDIC vector width
  localparam int AngW = 32;   // angle accumulator width, 1/65536 degree
  localparam int FiltW = 17;
  localparam int RollLimit = 46080;
  localparam int PitchLimit = 23040;
  localparam logic [17:0] GainQ16 = 18'd107922;

  localparam logic [1:0] RegAlpha = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegOneG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_PREP,
    ST_ROLL,
    ST_PITCH_MUL,
    ST_PITCH,
    ST_EMA,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic is_level;
  } tilt_t;

  typedef struct packed {
    logic start;
    logic signed [AccW-1:0] px;
    logic signed [AccW-1:0] py;
  } cordic_cmd_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    begin
      case (i)
        5'd0: v = 32'sd2949120;
        5'd1: v = 32'sd1740967;
        5'd2: v = 32'sd919879;
        5'd3: v = 32'sd466945;
        5'd4: v = 32'sd234379;
        5'd5: v = 32'sd117304;
        5'd6: v = 32'sd58666;
        5'd7: v = 32'sd29335;
        5'd8: v = 32'sd14668;
        5'd9: v = 32'sd7334;
        5'd10: v = 32'sd3667;
        5'd11: v = 32'sd1833;
        5'd12: v = 32'sd917;
        5'd13: v = 32'sd458;
        5'd14: v = 32'sd229;
        5'd15: v = 32'sd115;
        5'd16: v = 32'sd57;
        5'd17: v = 32'sd29;
        5'd18: v = 32'sd14;
        5'd19: v = 32'sd7;
        5'd20: v = 32'sd4;
        5'd21: v = 32'sd2;
        5'd22: v = 32'sd1;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: hdl/tilt_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt stream interface
// Valid/ready channel carrying a payload of parameterized type.
// ----------------------------------------------------------------------------
interface tilt_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/accel_tilt_angle_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer tilt angle filter
// Calibrated roll and pitch by CORDIC with exponential smoothing.
// ----------------------------------------------------------------------------
// Usage: samples arrive on in_ch (kind, accel_x/y/z). Calibration samples
// (kind 0) are summed; after CalibCount of them the offsets are updated and
// no result is produced. Measurement samples (kind 1) produce one result on
// out_ch: filtered roll, filtered pitch and a level flag.
// A measurement result comes from the shared CORDIC unit, which resolves one
// micro-rotation per cycle for roll and then for pitch; the EMA then runs on
// two multipliers. Calibration samples are taken one per cycle while idle;
// the one that completes a run is followed by bit-serial division that finds
// the offsets. One sample is in flight at a time.
// Reset clears sums, offsets, filter state and restores register defaults.
// If the receiver stalls, the result stays in the output register and no
// new sample is taken until the transaction completes.
// Configuration writes go through cfg_we/cfg_index/cfg_data; the user must make them while idle (not enforced).
// ----------------------------------------------------------------------------
module accel_tilt_angle_filter #(
  parameter int CalibCount = tilt_pkg::CalibCountDefault,
  parameter int CordicSteps = tilt_pkg::CordicStepsDefault
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [15:0] cfg_data,
  tilt_stream_if.sink in_ch,
  tilt_stream_if.source out_ch
);
  localparam int SumW = $clog2(CalibCount) + 17;
  localparam int CntW = $clog2(CalibCount + 1);
  localparam int DivW = SumW + 1;
  localparam int RemW = $clog2(CalibCount) + 2;
  localparam int DivCntW = $clog2(DivW);
  localparam int AccW = tilt_pkg::AccW;

  logic [15:0] alpha, threshold;
  logic [14:0] one_g;
  logic signed [SumW-1:0] sum_x, sum_y, sum_z;
  logic [CntW-1:0] calib_counter;
  logic signed [16:0] offset_x, offset_y, offset_z;
  logic signed [16:0] filt_roll, filt_pitch;
  logic signed [17:0] x, y, z;
  logic signed [AccW-1:0] mag_r, nx;
  logic signed [17:0] roll, pitch;
  logic [1:0] ema_phase;
  logic signed [51:0] ema_acc;
  tilt_pkg::state_t state, state_next;
  tilt_pkg::cordic_cmd_t cmd;
  logic c_busy, c_done;
  logic signed [AccW-1:0] c_mag;
  logic signed [tilt_pkg::AngW-1:0] c_angle;

  logic signed [17:0] x_neg;
  logic signed [36:0] gain_prod;
  logic [16:0] keep_w;
  logic signed [17:0] fresh_sel;
  logic signed [16:0] held_sel;
  logic signed [35:0] prod_fresh, prod_keep;

  logic signed [SumW-1:0] cal_sum [3];
  logic signed [DivW-1:0] cal_round [3];
  logic [DivW-1:0] div_load [3];
  logic [DivW-1:0] div_q [3];
  logic [RemW-1:0] div_rem [3];
  logic div_neg [3];
  logic [RemW-1:0] div_trial [3];
  logic div_bit [3];
  logic [DivW-1:0] div_q_next [3];
  logic signed [16:0] div_mean [3];
  logic [DivCntW-1:0] div_count;

  tilt_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk(clk), .rst(rst), .cmd(cmd), .busy(c_busy), .done(c_done),
    .mag(c_mag), .angle(c_angle)
  );

  function automatic logic signed [17:0] to_angle(input logic signed [31:0] a,
                                                 input int limit);
    logic signed [31:0] v;
    begin
      v = (a + 32'sd128) >>> 8;
      if (v > limit) v = limit;
      if (v < -limit) v = -limit;
      return 18'(v);
    end
  endfunction

  // The rounded mean is a floor division by CalibCount. Each axis runs a
  // restoring divider on the magnitude: dividend bits shift out at the top
  // while quotient bits shift in at the bottom.
  always_comb begin
    cal_sum[0] = sum_x + SumW'(in_ch.data.accel_x);
    cal_sum[1] = sum_y + SumW'(in_ch.data.accel_y);
    cal_sum[2] = sum_z + SumW'(in_ch.data.accel_z);
    for (int k = 0; k < 3; k++) begin
      cal_round[k] = {cal_sum[k][SumW-1], cal_sum[k]} + DivW'(CalibCount / 2);
      div_load[k] = cal_round[k][DivW-1] ?
                    DivW'(-cal_round[k]) + DivW'(CalibCount - 1) : DivW'(cal_round[k]);
      div_trial[k] = {div_rem[k][RemW-2:0], div_q[k][DivW-1]};
      div_bit[k] = (div_trial[k] >= RemW'(CalibCount));
      div_q_next[k] = {div_q[k][DivW-2:0], div_bit[k]};
      div_mean[k] = div_neg[k] ? -$signed(17'(div_q_next[k])) :
                    $signed(17'(div_q_next[k]));
    end
  end

  assign x_neg = -x;
  assign gain_prod = x_neg * $signed({1'b0, tilt_pkg::GainQ16});

  assign keep_w = 17'd65536 - {1'b0, alpha};
  assign fresh_sel = (ema_phase == 2'd0) ? roll : pitch;
  assign held_sel = (ema_phase == 2'd1) ? filt_roll : filt_pitch;
  assign prod_fresh = $signed({1'b0, alpha}) * fresh_sel;
  assign prod_keep = $signed({1'b0, keep_w}) * held_sel;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 16'd9830;
      threshold <= 16'd512;
      one_g <= 15'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tilt_pkg::RegAlpha: alpha <= cfg_data;
        tilt_pkg::RegThreshold: threshold <= cfg_data;
        tilt_pkg::RegOneG: one_g <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tilt_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.kind) state_next = tilt_pkg::ST_PREP;
          else if (calib_counter == CntW'(CalibCount - 1)) state_next = tilt_pkg::ST_MEAN;
        end
      end
      tilt_pkg::ST_MEAN:
        if (div_count == DivCntW'(DivW - 1)) state_next = tilt_pkg::ST_IDLE;
      tilt_pkg::ST_PREP: state_next = tilt_pkg::ST_ROLL;
      tilt_pkg::ST_ROLL: if (c_done) state_next = tilt_pkg::ST_PITCH_MUL;
      tilt_pkg::ST_PITCH_MUL: state_next = tilt_pkg::ST_PITCH;
      tilt_pkg::ST_PITCH: if (c_done) state_next = tilt_pkg::ST_EMA;
      tilt_pkg::ST_EMA: if (ema_phase == 2'd3) state_next = tilt_pkg::ST_OUT;
      tilt_pkg::ST_OUT: if (out_ch.ready) state_next = tilt_pkg::ST_IDLE;
      default: state_next = tilt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == tilt_pkg::ST_IDLE);
    out_ch.valid = (state == tilt_pkg::ST_OUT);
    cmd.start = 1'b0;
    cmd.px = '0;
    cmd.py = '0;
    if (state == tilt_pkg::ST_PREP) begin
      cmd.start = 1'b1;
      cmd.px = AccW'(z) <<< 14;
      cmd.py = AccW'(y) <<< 14;
    end else if (state == tilt_pkg::ST_PITCH_MUL) begin
      cmd.start = 1'b1;
      cmd.px = mag_r;
      cmd.py = nx;
    end
  end

  assign out_ch.data.roll_angle = filt_roll;
  assign out_ch.data.pitch_angle = filt_pitch[15:0];
  assign out_ch.data.is_level =
    ((filt_roll < 0 ? -filt_roll : filt_roll) < $signed({2'b0, threshold})) &&
    ((filt_pitch < 0 ? -filt_pitch : filt_pitch) < $signed({2'b0, threshold}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tilt_pkg::ST_IDLE;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      calib_counter <= '0;
      offset_x <= '0; offset_y <= '0; offset_z <= '0;
      filt_roll <= '0; filt_pitch <= '0;
      ema_phase <= '0;
    end else begin
      state <= state_next;
      if (in_ch.valid && in_ch.ready) begin
        if (!in_ch.data.kind) begin
          if (calib_counter == CntW'(CalibCount - 1)) begin
            for (int k = 0; k < 3; k++) begin
              div_q[k] <= div_load[k];
              div_rem[k] <= '0;
              div_neg[k] <= cal_round[k][DivW-1];
            end
            div_count <= '0;
            sum_x <= '0; sum_y <= '0; sum_z <= '0;
            calib_counter <= '0;
          end else begin
            sum_x <= cal_sum[0];
            sum_y <= cal_sum[1];
            sum_z <= cal_sum[2];
            calib_counter <= calib_counter + 1'b1;
          end
        end else begin
          x <= 18'(in_ch.data.accel_x) - 18'(offset_x);
          y <= 18'(in_ch.data.accel_y) - 18'(offset_y);
          z <= 18'(in_ch.data.accel_z) - 18'(offset_z);
        end
      end
      if (state == tilt_pkg::ST_MEAN) begin
        for (int k = 0; k < 3; k++) begin
          div_q[k] <= div_q_next[k];
          div_rem[k] <= div_bit[k] ? div_trial[k] - RemW'(CalibCount) : div_trial[k];
        end
        div_count <= div_count + 1'b1;
        if (div_count == DivCntW'(DivW - 1)) begin
          offset_x <= div_mean[0];
          offset_y <= div_mean[1];
          offset_z <= div_mean[2] - $signed({2'b0, one_g});
        end
      end
      if (state == tilt_pkg::ST_ROLL && c_done) begin
        mag_r <= c_mag;
        roll <= to_angle(c_angle, tilt_pkg::RollLimit);
        nx <= AccW'(gain_prod >>> 2);
      end
      if (state == tilt_pkg::ST_PITCH && c_done) begin
        pitch <= to_angle(c_angle, tilt_pkg::PitchLimit);
        ema_phase <= '0;
      end
      if (state == tilt_pkg::ST_EMA) begin
        ema_phase <= ema_phase + 1'b1;
        unique case (ema_phase)
          2'd0: ema_acc <= 52'(prod_fresh) + 52'sd32768;
          2'd1: begin
            filt_roll <= 17'((ema_acc + 52'(prod_keep)) >>> 16);
            ema_acc <= 52'(prod_fresh) + 52'sd32768;
          end
          2'd2: filt_pitch <= 17'((ema_acc + 52'(prod_keep)) >>> 16);
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid && !c_busy) else $error("accept while busy");
  a_cordic_idle: assert property (@(posedge clk) disable iff (rst)
    state == tilt_pkg::ST_EMA |-> !c_busy) else $error("cordic busy in filter");
`endif
endmodule

FILE: hdl/tilt_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt CORDIC vectoring unit
// Iterative atan2 in 1/65536 degree, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tilt_cordic #(
  parameter int CordicSteps = tilt_pkg::CordicStepsDefault
) (
  input  logic clk,
  input  logic rst,
  input  tilt_pkg::cordic_cmd_t cmd,
  output logic busy,
  output logic done,
  output logic signed [tilt_pkg::AccW-1:0] mag,
  output logic signed [tilt_pkg::AngW-1:0] angle
);
  localparam int StepW = $clog2(CordicSteps + 1);

  logic signed [tilt_pkg::AccW-1:0] px, py;
  logic signed [tilt_pkg::AngW-1:0] acc;
  logic [StepW-1:0] step;
  logic running;
  logic signed [tilt_pkg::AccW-1:0] tx, ty;
  logic [4:0] idx;

  assign idx = 5'(step);
  assign tx = px >>> step;
  assign ty = py >>> step;
  assign busy = running;
  assign mag = px;
  assign angle = acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      step <= '0;
    end else if (cmd.start) begin
      step <= '0;
      if (cmd.px == 0 && cmd.py == 0) begin
        px <= '0;
        py <= '0;
        acc <= '0;
        done <= 1'b1;
        running <= 1'b0;
      end else if (cmd.px < 0) begin
        px <= -cmd.px;
        py <= -cmd.py;
        acc <= (cmd.py >= 0) ? 32'sd11796480 : -32'sd11796480;
        running <= 1'b1;
      end else begin
        px <= cmd.px;
        py <= cmd.py;
        acc <= '0;
        running <= 1'b1;
      end
    end else if (running) begin
      if (py > 0) begin
        px <= px + ty;
        py <= py - tx;
        acc <= acc + tilt_pkg::atan_entry(idx);
      end else begin
        px <= px - ty;
        py <= py + tx;
        acc <= acc - tilt_pkg::atan_entry(idx);
      end
      if (step == StepW'(CordicSteps - 1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done || $past(cmd.start)) else $error("done held");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    running |-> step < StepW'(CordicSteps)) else $error("step overrun");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("done while running");
`endif
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt filter testbench
// Drives raw accelerometer samples into the tilt filter with random idling on
// both channels, predicts calibrated, smoothed roll and pitch with a CORDIC
// written here, and compares every result field by field in order.
// ----------------------------------------------------------------------------
typedef enum logic {KIND_CALIB = 1'b0, KIND_MEAS = 1'b1} sample_kind_t;

class tilt_scoreboard;
  localparam int CalibLen = 256;
  localparam int Steps = 16;
  localparam longint Gain = 107922;

  longint arctan[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                         14, 7, 4, 2, 1, 0};
  longint alpha = 9830, threshold = 512, one_g = 2048;
  longint sum_x, sum_y, sum_z, off_x, off_y, off_z, filt_roll, filt_pitch;
  int calib_seen;
  int errors;
  tilt_pkg::tilt_t pending[$];

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == tilt_pkg::RegAlpha) alpha = val;
    else if (idx == tilt_pkg::RegThreshold) threshold = val;
    else if (idx == tilt_pkg::RegOneG) one_g = val[14:0];
  endfunction

  // Returns the angle of (px, py) in 1/65536 degree; mag gets the scaled length.
  function longint vector_angle(longint px, longint py, output longint mag);
    longint acc, tx, ty;
    acc = 0;
    mag = 0;
    if (px == 0 && py == 0) return 0;
    if (px < 0) begin
      acc = (py >= 0) ? 180 * 65536 : -180 * 65536;
      px = -px;
      py = -py;
    end
    for (int i = 0; i < Steps; i++) begin
      tx = px >>> i;
      ty = py >>> i;
      if (py > 0) begin
        px += ty; py -= tx; acc += arctan[i];
      end else begin
        px -= ty; py += tx; acc -= arctan[i];
      end
    end
    mag = px;
    return acc;
  endfunction

  function longint clamp_angle(longint acc, longint lim);
    longint a;
    a = (acc + 128) >>> 8;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function longint smooth(longint old, longint fresh);
    return (alpha * fresh + (65536 - alpha) * old + 32768) >>> 16;
  endfunction

  function void note_sample(tilt_pkg::sample_t s);
    longint x, y, z, r, dummy, roll, pitch, ar, ap;
    tilt_pkg::tilt_t t;
    if (s.kind == KIND_CALIB) begin
      sum_x += s.accel_x; sum_y += s.accel_y; sum_z += s.accel_z;
      calib_seen++;
      if (calib_seen >= CalibLen) begin
        off_x = (sum_x + CalibLen / 2) >>> 8;
        off_y = (sum_y + CalibLen / 2) >>> 8;
        off_z = ((sum_z + CalibLen / 2) >>> 8) - one_g;
        sum_x = 0; sum_y = 0; sum_z = 0;
        calib_seen = 0;
      end
      return;
    end
    x = longint'(s.accel_x) - off_x;
    y = longint'(s.accel_y) - off_y;
    z = longint'(s.accel_z) - off_z;
    roll = clamp_angle(vector_angle(z * 16384, y * 16384, r), tilt_pkg::RollLimit);
    pitch = clamp_angle(vector_angle(r, (-x * Gain) >>> 2, dummy), tilt_pkg::PitchLimit);
    filt_roll = smooth(filt_roll, roll);
    filt_pitch = smooth(filt_pitch, pitch);
    ar = filt_roll < 0 ? -filt_roll : filt_roll;
    ap = filt_pitch < 0 ? -filt_pitch : filt_pitch;
    t.roll_angle = filt_roll[16:0];
    t.pitch_angle = filt_pitch[15:0];
    t.is_level = (ar < threshold) && (ap < threshold);
    pending.push_back(t);
  endfunction

  function void check_result(tilt_pkg::tilt_t got);
    tilt_pkg::tilt_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result roll=%0d pitch=%0d level=%0d", $time,
               got.roll_angle, got.pitch_angle, got.is_level);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.roll_angle !== want.roll_angle) begin
      $display("%0t: roll_angle expected %0d actual %0d", $time,
               want.roll_angle, got.roll_angle);
      errors++;
    end
    if (got.pitch_angle !== want.pitch_angle) begin
      $display("%0t: pitch_angle expected %0d actual %0d", $time,
               want.pitch_angle, got.pitch_angle);
      errors++;
    end
    if (got.is_level !== want.is_level) begin
      $display("%0t: is_level expected %0d actual %0d", $time,
               want.is_level, got.is_level);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam logic [1:0] RegNone = 2'd3;
  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = tilt_pkg::RegAlpha;
  logic [15:0] cfg_data = '0;
  logic calm = 1'b0;
  int idle_cycles = 0;

  tilt_stream_if #(.payload_t(tilt_pkg::sample_t)) in_ch (clk);
  tilt_stream_if #(.payload_t(tilt_pkg::tilt_t)) out_ch (clk);

  tilt_scoreboard board = new();

  accel_tilt_angle_filter u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_sample(in_ch.data);
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send(logic kind, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    tilt_pkg::sample_t s;
    s.kind = kind; s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Waits out outstanding results, then covers a calibration still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  // Mostly samples near a tilted gravity vector, some full-range noise.
  task automatic random_sample(logic kind);
    if ($urandom_range(3) == 0)
      send(kind, $urandom, $urandom, $urandom);
    else
      send(kind, 16'($signed($urandom_range(4000)) - 2000),
           16'($signed($urandom_range(4000)) - 2000),
           16'($signed($urandom_range(4400)) - 200));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners with zero offsets and the reset settings.
    send(KIND_MEAS, 16'd0, 16'd0, 16'd0);
    send(KIND_MEAS, 16'd0, 16'd0, -16'sd1000);
    send(KIND_MEAS, 16'd0, 16'd1, -16'sd32768);
    send(KIND_MEAS, 16'd0, -16'sd1, -16'sd32768);
    send(KIND_MEAS, -16'sd32768, 16'd0, 16'd0);
    send(KIND_MEAS, 16'sd32767, 16'd0, 16'd0);
    send(KIND_MEAS, 16'sd32767, 16'sd32767, 16'sd32767);
    send(KIND_MEAS, -16'sd32768, -16'sd32768, -16'sd32768);
    send(KIND_MEAS, 16'd0, 16'sd32767, 16'd0);
    send(KIND_MEAS, 16'd0, -16'sd32768, 16'd0);
    send(KIND_MEAS, 16'd10, 16'd5, 16'sd2048);
    drain();
    write_reg(tilt_pkg::RegAlpha, 16'd65535);
    write_reg(tilt_pkg::RegThreshold, 16'd46080);
    write_reg(tilt_pkg::RegOneG, 16'd1);
    write_reg(RegNone, 16'hFFFF);
    send(KIND_MEAS, 16'd100, -16'sd200, 16'sd2000);
    send(KIND_MEAS, -16'sd300, 16'd20, -16'sd2000);
    drain();
    write_reg(tilt_pkg::RegAlpha, 16'd0);
    write_reg(tilt_pkg::RegThreshold, 16'd0);
    write_reg(tilt_pkg::RegOneG, 16'h7FFF);
    send(KIND_MEAS, 16'd1, 16'd1, 16'd1);
    drain();
    write_reg(tilt_pkg::RegOneG, 16'hFFFF);

    // Calibration run at the extremes of the sums.
    calm = 1'b1;
    for (int i = 0; i < 256; i++)
      send(KIND_CALIB, (i % 2) ? 16'sd32767 : -16'sd32768, 16'sd32767, -16'sd32768);
    calm = 1'b0;
    send(KIND_MEAS, 16'd0, 16'd0, 16'd0);
    send(KIND_MEAS, 16'sd32767, -16'sd32768, 16'sd32767);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(tilt_pkg::RegAlpha, (phase == 3) ? 16'd9830 : 16'($urandom));
      write_reg(tilt_pkg::RegThreshold,
                (phase == 2) ? 16'd46080 : 16'($urandom_range(46080)));
      write_reg(tilt_pkg::RegOneG, (phase == 1) ? 16'd0 : 16'($urandom_range(32767, 1)));
      calm = (phase == 2);
      for (int i = 0; i < 155; i++)
        random_sample(($urandom_range(99) < 45) ? KIND_CALIB : KIND_MEAS);
      calm = 1'b0;
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
